@@ rtl/core/sscg_pkg.sv @@
// types, constants and helpers shared by the shadow stack checker
package sscg_pkg;

  localparam int VERTICES    = 64;
  localparam int STACK_DEPTH = 32;
  localparam int ID_W        = 6;
  localparam int DEPTH_OUT_W = 6;
  localparam int VADDR_W     = (VERTICES > 1) ? $clog2(VERTICES) : 1;
  localparam int SADDR_W     = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);

  typedef enum logic [1:0] {
    CMD_PUSH   = 2'd0,
    CMD_POP    = 2'd1,
    CMD_VERIFY = 2'd2,
    CMD_EDGE   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_VIOLATION = 3'd1,
    ST_UNDERFLOW = 3'd2,
    ST_OVERFLOW  = 3'd3,
    ST_MISMATCH  = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP_CMP,
    S_EDGE_WR,
    S_V_FIRST,
    S_V_ROW,
    S_V_CHK
  } state_t;

  typedef struct packed {
    logic [1:0]      command;
    logic [ID_W-1:0] func_id;
    logic [ID_W-1:0] callee_id;
    logic            edge_allowed;
  } in_item_t;

  typedef struct packed {
    status_t                status;
    logic [DEPTH_OUT_W-1:0] depth_now;
    logic                   tripped;
  } out_item_t;

  function automatic logic id_ok(input logic [ID_W-1:0] id);
    return (int'(id) < VERTICES);
  endfunction

endpackage

@@ rtl/core/sscg_ram.sv @@
// generic single write port ram with registered read
module sscg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/shadow_stack_call_graph_checker.sv @@
// top level: shadow stack with call edge matrix and verify sequencer
// push, short-stack verify, edge writes to out-of-range ids and underflow: result in the next cycle
// pop and edge write: result registered from S_POP_CMP or S_EDGE_WR; busy for 1 cycle
// verify on depth d: S_V_FIRST reads the bottom entry, then S_V_ROW and S_V_CHK for each pair
// the pair walk shares one stack read port and one matrix row read port
// synchronous reset empties the stack, clears all edge rows via row valid bits and the sticky flag
module shadow_stack_call_graph_checker
  import sscg_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  state_t                 state_r, state_nxt;
  in_item_t               cmd_r;
  logic [DEPTH_W-1:0]     depth_r, depth_nxt;
  logic                   tripped_r, tripped_nxt;
  logic [ID_W-1:0]        prev_r, prev_nxt;
  logic [ID_W-1:0]        cur_r, cur_nxt;
  logic [SADDR_W-1:0]     idx_r, idx_nxt;
  logic [VERTICES-1:0]    row_vld_r, row_vld_nxt;
  logic                   out_valid_r, res_vld;
  out_item_t              out_item_r;
  status_t                res_status;

  logic                   accept;
  logic                   stk_we;
  logic [SADDR_W-1:0]     stk_waddr, stk_raddr;
  logic [ID_W-1:0]        stk_wdata, stk_rdata;
  logic                   row_we;
  logic [VADDR_W-1:0]     row_waddr, row_raddr;
  logic [VERTICES-1:0]    row_wdata, row_rdata;
  logic                   pair_ok;
  logic                   last_pair;
  logic [DEPTH_W-1:0]     idx_inc;

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign idx_inc   = DEPTH_W'(idx_r) + DEPTH_W'(1);
  assign last_pair = (idx_inc == depth_r);
  assign pair_ok   = id_ok(prev_r) && id_ok(cur_r) &&
                     row_vld_r[VADDR_W'(prev_r)] && row_rdata[VADDR_W'(cur_r)];

  sscg_ram #(.WIDTH(ID_W), .DEPTH(STACK_DEPTH)) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  sscg_ram #(.WIDTH(VERTICES), .DEPTH(VERTICES)) u_edge_ram (
    .clk   (clk),
    .we    (row_we),
    .waddr (row_waddr),
    .wdata (row_wdata),
    .raddr (row_raddr),
    .rdata (row_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (cmd_t'(in_item.command))
            CMD_POP: begin
              if (depth_r != '0) state_nxt = S_POP_CMP;
            end
            CMD_VERIFY: begin
              if (depth_r >= DEPTH_W'(2)) state_nxt = S_V_FIRST;
            end
            CMD_EDGE: begin
              if (id_ok(in_item.func_id) && id_ok(in_item.callee_id)) state_nxt = S_EDGE_WR;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_POP_CMP: state_nxt = S_IDLE;
      S_EDGE_WR: state_nxt = S_IDLE;
      S_V_FIRST: state_nxt = S_V_ROW;
      S_V_ROW:   state_nxt = S_V_CHK;
      S_V_CHK: begin
        if (!pair_ok || last_pair) state_nxt = S_IDLE;
        else state_nxt = S_V_ROW;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and result
  always_comb begin
    stk_we      = 1'b0;
    stk_waddr   = SADDR_W'(depth_r);
    stk_wdata   = in_item.func_id;
    stk_raddr   = '0;
    row_we      = 1'b0;
    row_waddr   = VADDR_W'(cmd_r.func_id);
    row_wdata   = row_vld_r[VADDR_W'(cmd_r.func_id)] ? row_rdata : '0;
    row_raddr   = VADDR_W'(in_item.func_id);
    depth_nxt   = depth_r;
    tripped_nxt = tripped_r;
    prev_nxt    = prev_r;
    cur_nxt     = cur_r;
    idx_nxt     = idx_r;
    row_vld_nxt = row_vld_r;
    res_vld     = 1'b0;
    res_status  = ST_OK;
    case (state_r)
      S_IDLE: begin
        stk_raddr = SADDR_W'(depth_r - DEPTH_W'(1));
        if (accept) begin
          case (cmd_t'(in_item.command))
            CMD_PUSH: begin
              res_vld = 1'b1;
              if (depth_r >= DEPTH_W'(STACK_DEPTH)) begin
                res_status = ST_OVERFLOW;
              end else begin
                stk_we    = 1'b1;
                depth_nxt = depth_r + DEPTH_W'(1);
              end
            end
            CMD_POP: begin
              if (depth_r == '0) begin
                res_vld    = 1'b1;
                res_status = ST_UNDERFLOW;
              end
            end
            CMD_VERIFY: begin
              stk_raddr = '0;
              idx_nxt   = '0;
              if (depth_r < DEPTH_W'(2)) res_vld = 1'b1;
            end
            CMD_EDGE: begin
              if (!(id_ok(in_item.func_id) && id_ok(in_item.callee_id))) res_vld = 1'b1;
            end
            default: res_vld = 1'b0;
          endcase
        end
      end
      S_POP_CMP: begin
        res_vld = 1'b1;
        if (stk_rdata == cmd_r.func_id) depth_nxt = depth_r - DEPTH_W'(1);
        else res_status = ST_MISMATCH;
      end
      S_EDGE_WR: begin
        res_vld = 1'b1;
        row_we  = 1'b1;
        row_wdata[VADDR_W'(cmd_r.callee_id)] = cmd_r.edge_allowed;
        row_vld_nxt[VADDR_W'(cmd_r.func_id)] = 1'b1;
      end
      S_V_FIRST: begin
        prev_nxt  = stk_rdata;
        stk_raddr = SADDR_W'(idx_inc);
        idx_nxt   = SADDR_W'(idx_inc);
      end
      S_V_ROW: begin
        cur_nxt   = stk_rdata;
        row_raddr = VADDR_W'(prev_r);
      end
      S_V_CHK: begin
        stk_raddr = SADDR_W'(idx_inc);
        if (!pair_ok) begin
          res_vld     = 1'b1;
          res_status  = ST_VIOLATION;
          tripped_nxt = 1'b1;
        end else if (last_pair) begin
          res_vld = 1'b1;
        end else begin
          prev_nxt = cur_r;
          idx_nxt  = SADDR_W'(idx_inc);
        end
      end
      default: res_vld = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      depth_r     <= '0;
      tripped_r   <= 1'b0;
      row_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      depth_r     <= depth_nxt;
      tripped_r   <= tripped_nxt;
      row_vld_r   <= row_vld_nxt;
      out_valid_r <= res_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_item;
    end
    prev_r <= prev_nxt;
    cur_r  <= cur_nxt;
    idx_r  <= idx_nxt;
    if (res_vld) begin
      out_item_r.status    <= res_status;
      out_item_r.depth_now <= DEPTH_OUT_W'(depth_nxt);
      out_item_r.tripped   <= tripped_nxt;
    end
  end

  a_result_only_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == S_IDLE))
    else $error("result transfer while sequencer busy");

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= DEPTH_W'(STACK_DEPTH))
    else $error("stack depth beyond capacity");

  a_tripped_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    tripped_r |=> tripped_r)
    else $error("sticky violation flag cleared");

  a_walk_in_stack: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_V_CHK) |-> (idx_inc <= depth_r))
    else $error("verify walk past top of stack");

  a_busy_means_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (state_nxt == S_IDLE)) |=> out_valid_r)
    else $error("quick command gave no result");

endmodule
